@@ hdl/caalu_pkg.sv @@
// Package for the complex accumulator ALU: widths, command codes, saturation helpers.
package caalu_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int CMD_W         = 3;
   localparam int MW            = 2 * VALUE_WIDTH + 1;
   localparam int NW            = MW + FRACTION_BITS;
   localparam int QB            = VALUE_WIDTH + 1;
   localparam int CW            = $clog2(QB);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4,
      CMD_SWAP = 3'd5,
      CMD_ABS  = 3'd6,
      CMD_NOP  = 3'd7
   } cmd_type;

   typedef struct packed {
      logic                   ovf;
      logic [VALUE_WIDTH-1:0] val;
   } sat_type;

   function automatic logic [MW-1:0] sext(input logic [VALUE_WIDTH-1:0] x);
      return {{(MW-VALUE_WIDTH){x[VALUE_WIDTH-1]}}, x};
   endfunction

   function automatic logic [MW-1:0] magnitude(input logic [MW-1:0] v);
      return v[MW-1] ? (MW'(0) - v) : v;
   endfunction

   function automatic sat_type saturate(input logic neg, input logic [MW-1:0] mag);
      sat_type       r;
      logic [MW-1:0] lim;
      lim = neg ? (MW'(1) << (VALUE_WIDTH - 1)) : ((MW'(1) << (VALUE_WIDTH - 1)) - MW'(1));
      if (mag > lim) begin
         r.ovf = 1'b1;
         r.val = lim[VALUE_WIDTH-1:0];
      end else begin
         r.ovf = 1'b0;
         r.val = neg ? (VALUE_WIDTH'(0) - mag[VALUE_WIDTH-1:0]) : mag[VALUE_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/complex_accumulator_alu.sv @@
// Complex accumulator ALU: shared multiplier and radix-2 divider under a sequencer.
// Load/add/sub/swap/abs/nop and divide by zero go straight to the finish state; multiply runs
// the shared multiplier; divide runs the multiplier, then the restoring divider for each part.
// One request at a time; the next is taken once the previous result is registered.
// Synchronous reset clears the accumulator to zero with the known flag set.
module complex_accumulator_alu import caalu_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [CMD_W-1:0]              req_cmd,
   input  logic signed [VALUE_WIDTH-1:0] req_operand_real,
   input  logic signed [VALUE_WIDTH-1:0] req_operand_imag,
   input  logic                          req_operand_known,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_result_real,
   output logic signed [VALUE_WIDTH-1:0] rsp_result_imag,
   output logic                          rsp_result_known,
   output logic                          rsp_overflow,
   output logic                          rsp_divide_by_zero
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV_INIT, ST_DIV_RUN, ST_FINISH
   } state_type;

   state_type                state_ff;
   cmd_type                  cmd_ff;
   logic [VALUE_WIDTH-1:0]   acc_real_ff, acc_imag_ff, b_real_ff, b_imag_ff;
   logic                     acc_known_ff, b_known_ff, ovf_ff, dz_ff, rsp_valid_ff;
   logic                     dz_out_ff;
   logic [2:0]               step_ff, tag_ff;
   logic                     pv_ff;
   logic signed [2*VALUE_WIDTH-1:0] p_ff;
   logic [MW-1:0]            sre_ff, sim_ff, den_ff, rem_ff;
   logic [QB-1:0]            nbits_ff, q_ff, qr_ff, qi_ff;
   logic [1:0]               big_ff, negq_ff;
   logic                     part_ff;
   logic [CW-1:0]            cnt_ff;

   logic signed [VALUE_WIDTH-1:0] mx, my;
   logic [MW-1:0]            p_ext, add_src, add_res, num, nmag, t_val;
   logic [NW-1:0]            nshift;
   logic [2:0]               n_steps;
   logic                     sub_sel, ge;
   logic [MW-1:0]            vr, vi, mag_r, mag_i;
   logic                     neg_r, neg_i;
   sat_type                  sr, si;
   logic [VALUE_WIDTH-1:0]   nr_in, ni_in;
   logic                     known_in, ovf_in;

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_real    = acc_real_ff;
   assign rsp_result_imag    = acc_imag_ff;
   assign rsp_result_known   = acc_known_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_divide_by_zero = dz_out_ff;

   // shared multiplier operand schedule
   always_comb begin
      unique case (step_ff)
         3'd0:    begin mx = acc_real_ff; my = b_real_ff; end
         3'd1:    begin mx = acc_imag_ff; my = b_imag_ff; end
         3'd2:    begin mx = acc_real_ff; my = b_imag_ff; end
         3'd3:    begin mx = acc_imag_ff; my = b_real_ff; end
         3'd4:    begin mx = b_real_ff;   my = b_real_ff; end
         default: begin mx = b_imag_ff;   my = b_imag_ff; end
      endcase
   end

   assign n_steps = (cmd_ff == CMD_MUL) ? 3'd4 : 3'd6;
   assign p_ext   = {p_ff[2*VALUE_WIDTH-1], p_ff};
   assign sub_sel = ((tag_ff == 3'd1) && (cmd_ff == CMD_MUL)) ||
                    ((tag_ff == 3'd2) && (cmd_ff == CMD_DIV));

   always_comb begin
      unique case (tag_ff)
         3'd0, 3'd1: add_src = sre_ff;
         3'd2, 3'd3: add_src = sim_ff;
         default:    add_src = den_ff;
      endcase
      add_res = sub_sel ? (add_src - p_ext) : (add_src + p_ext);
   end

   // divider
   assign num    = part_ff ? sim_ff : sre_ff;
   assign nmag   = magnitude(num);
   assign nshift = NW'(nmag) << FRACTION_BITS;
   assign t_val  = {rem_ff[MW-2:0], nbits_ff[QB-1]};
   assign ge     = (t_val >= den_ff);

   // final value per part
   always_comb begin
      vr = sext(acc_real_ff);
      vi = sext(acc_imag_ff);
      unique case (cmd_ff)
         CMD_LOAD: begin vr = sext(b_real_ff); vi = sext(b_imag_ff); end
         CMD_ADD:  begin
            vr = sext(acc_real_ff) + sext(b_real_ff);
            vi = sext(acc_imag_ff) + sext(b_imag_ff);
         end
         CMD_SUB:  begin
            vr = sext(acc_real_ff) - sext(b_real_ff);
            vi = sext(acc_imag_ff) - sext(b_imag_ff);
         end
         CMD_SWAP: begin vr = sext(acc_imag_ff); vi = sext(acc_real_ff); end
         default:  ;
      endcase
      neg_r = vr[MW-1];
      neg_i = vi[MW-1];
      mag_r = magnitude(vr);
      mag_i = magnitude(vi);
      unique case (cmd_ff)
         CMD_MUL: begin
            neg_r = sre_ff[MW-1];
            neg_i = sim_ff[MW-1];
            mag_r = magnitude(sre_ff) >> FRACTION_BITS;
            mag_i = magnitude(sim_ff) >> FRACTION_BITS;
         end
         CMD_DIV: begin
            neg_r = negq_ff[0];
            neg_i = negq_ff[1];
            mag_r = big_ff[0] ? '1 : MW'(qr_ff);
            mag_i = big_ff[1] ? '1 : MW'(qi_ff);
         end
         CMD_ABS: begin neg_r = 1'b0; neg_i = 1'b0; end
         default: ;
      endcase
      sr = saturate(neg_r, mag_r);
      si = saturate(neg_i, mag_i);
      if (dz_ff) begin
         ovf_in = 1'b0;
         nr_in  = (acc_real_ff == '0) ? '0 :
                  acc_real_ff[VALUE_WIDTH-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                             : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
         ni_in  = (acc_imag_ff == '0) ? '0 :
                  acc_imag_ff[VALUE_WIDTH-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                             : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end else begin
         ovf_in = sr.ovf | si.ovf;
         nr_in  = sr.val;
         ni_in  = si.val;
      end
      if (cmd_ff == CMD_LOAD)
         known_in = b_known_ff;
      else if ((cmd_ff <= CMD_DIV) && !b_known_ff)
         known_in = 1'b0;
      else
         known_in = acc_known_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_real_ff  <= '0;
         acc_imag_ff  <= '0;
         acc_known_ff <= 1'b1;
         ovf_ff       <= 1'b0;
         dz_ff        <= 1'b0;
         dz_out_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         part_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH))
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff     <= cmd_type'(req_cmd);
                  b_real_ff  <= req_operand_real;
                  b_imag_ff  <= req_operand_imag;
                  b_known_ff <= req_operand_known;
                  dz_ff      <= (cmd_type'(req_cmd) == CMD_DIV) &&
                                (req_operand_real == '0) && (req_operand_imag == '0);
                  sre_ff     <= '0;
                  sim_ff     <= '0;
                  den_ff     <= '0;
                  step_ff    <= '0;
                  pv_ff      <= 1'b0;
                  part_ff    <= 1'b0;
                  if ((cmd_type'(req_cmd) == CMD_MUL) ||
                      ((cmd_type'(req_cmd) == CMD_DIV) &&
                       ((req_operand_real != '0) || (req_operand_imag != '0))))
                     state_ff <= ST_MUL;
                  else
                     state_ff <= ST_FINISH;
               end
            end
            ST_MUL: begin
               if (pv_ff) begin
                  unique case (tag_ff)
                     3'd0, 3'd1: sre_ff <= add_res;
                     3'd2, 3'd3: sim_ff <= add_res;
                     default:    den_ff <= add_res;
                  endcase
               end
               if (step_ff < n_steps) begin
                  p_ff    <= mx * my;
                  tag_ff  <= step_ff;
                  pv_ff   <= 1'b1;
                  step_ff <= step_ff + 3'd1;
               end else begin
                  pv_ff <= 1'b0;
                  if (!pv_ff)
                     state_ff <= (cmd_ff == CMD_MUL) ? ST_FINISH : ST_DIV_INIT;
               end
            end
            ST_DIV_INIT: begin
               rem_ff            <= MW'(nshift[NW-1:QB]);
               nbits_ff          <= nshift[QB-1:0];
               big_ff[part_ff]   <= (MW'(nshift[NW-1:QB]) >= den_ff);
               negq_ff[part_ff]  <= num[MW-1];
               cnt_ff            <= '0;
               state_ff          <= ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
               rem_ff   <= ge ? (t_val - den_ff) : t_val;
               nbits_ff <= {nbits_ff[QB-2:0], 1'b0};
               q_ff     <= {q_ff[QB-2:0], ge};
               cnt_ff   <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(QB - 1)) begin
                  if (part_ff) begin
                     qi_ff    <= {q_ff[QB-2:0], ge};
                     state_ff <= ST_FINISH;
                  end else begin
                     qr_ff    <= {q_ff[QB-2:0], ge};
                     part_ff  <= 1'b1;
                     state_ff <= ST_DIV_INIT;
                  end
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  acc_real_ff  <= nr_in;
                  acc_imag_ff  <= ni_in;
                  acc_known_ff <= known_in;
                  ovf_ff       <= ovf_in;
                  dz_out_ff    <= dz_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_divide_by_zero))
      else $error("divide by zero reported with overflow");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while not busy afterwards");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (cnt_ff <= CW'(QB - 1)))
      else $error("divider step count out of range");

   a_finish_stalled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_FINISH))
      else $error("result overwritten while output stalled");

endmodule

@@ tb/tb.sv @@
// Testbench for complex_accumulator_alu: directed and random requests checked against a fixed-point predictor.
`timescale 1ns / 100ps

module tb;
   import caalu_pkg::*;

   typedef logic signed [129:0] wide_type;

   typedef struct {
      logic [VALUE_WIDTH-1:0] re;
      logic [VALUE_WIDTH-1:0] im;
      logic                   known;
      logic                   ovf;
      logic                   dz;
   } acc_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [CMD_W-1:0]              req_cmd = CMD_LOAD;
   logic signed [VALUE_WIDTH-1:0] req_operand_real = '0;
   logic signed [VALUE_WIDTH-1:0] req_operand_imag = '0;
   logic                          req_operand_known = 1'b1;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_result_real;
   logic signed [VALUE_WIDTH-1:0] rsp_result_imag;
   logic                          rsp_result_known;
   logic                          rsp_overflow;
   logic                          rsp_divide_by_zero;

   logic [VALUE_WIDTH-1:0] model_re = '0;
   logic [VALUE_WIDTH-1:0] model_im = '0;
   logic                   model_known = 1'b1;
   acc_result_type         pending_results[$];
   int                     mismatch_count = 0;
   int                     request_count = 0;
   int                     result_count = 0;
   int                     hold_count = 0;
   bit                     hold_go = 1'b0;
   bit                     hold_done = 1'b0;
   bit                     idle_on = 1'b1;

   complex_accumulator_alu dut (.*);

   always #5 clock = ~clock;

   function automatic wide_type drop_fraction(wide_type v);
      return (v < 0) ? -((-v) >>> FRACTION_BITS) : (v >>> FRACTION_BITS);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] clamp_part(wide_type v, inout logic ovf);
      wide_type hi = (wide_type'(1) <<< (VALUE_WIDTH - 1)) - 1;
      wide_type lo = -(wide_type'(1) <<< (VALUE_WIDTH - 1));
      if (v > hi) begin
         ovf = 1'b1;
         return hi[VALUE_WIDTH-1:0];
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo[VALUE_WIDTH-1:0];
      end
      return v[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] div_zero_part(wide_type v);
      if (v == 0) return '0;
      return (v < 0) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   endfunction

   function automatic acc_result_type accumulate(cmd_type c,
                                                 logic signed [VALUE_WIDTH-1:0] opr,
                                                 logic signed [VALUE_WIDTH-1:0] opi,
                                                 logic opk);
      acc_result_type r;
      wide_type ar = $signed(model_re);
      wide_type ai = $signed(model_im);
      wide_type br = opr;
      wide_type bi = opi;
      wide_type nr = ar;
      wide_type ni = ai;
      wide_type den;
      r.ovf = 1'b0;
      r.dz = 1'b0;
      case (c)
         CMD_LOAD: begin nr = br; ni = bi; end
         CMD_ADD:  begin nr = ar + br; ni = ai + bi; end
         CMD_SUB:  begin nr = ar - br; ni = ai - bi; end
         CMD_MUL: begin
            nr = drop_fraction(ar * br - ai * bi);
            ni = drop_fraction(ar * bi + ai * br);
         end
         CMD_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) r.dz = 1'b1;
            else begin
               nr = ((ar * br + ai * bi) <<< FRACTION_BITS) / den;
               ni = ((ai * br - ar * bi) <<< FRACTION_BITS) / den;
            end
         end
         CMD_SWAP: begin nr = ai; ni = ar; end
         CMD_ABS: begin
            nr = (ar < 0) ? -ar : ar;
            ni = (ai < 0) ? -ai : ai;
         end
         default: ;
      endcase
      if (r.dz) begin
         r.re = div_zero_part(ar);
         r.im = div_zero_part(ai);
      end else begin
         r.re = clamp_part(nr, r.ovf);
         r.im = clamp_part(ni, r.ovf);
      end
      if (c == CMD_LOAD) model_known = opk;
      else if (c inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV} && !opk) model_known = 1'b0;
      model_re = r.re;
      model_im = r.im;
      r.known = model_known;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_results.push_back(accumulate(cmd_type'(req_cmd), req_operand_real,
                                              req_operand_imag, req_operand_known));
         request_count++;
      end
   end

   always @(posedge clock) begin
      acc_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("ERROR: result with no request pending");
         end else begin
            e = pending_results.pop_front();
            if (rsp_result_real !== e.re || rsp_result_imag !== e.im ||
                rsp_result_known !== e.known || rsp_overflow !== e.ovf ||
                rsp_divide_by_zero !== e.dz) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: exp re=%h im=%h k=%b ov=%b dz=%b got re=%h im=%h k=%b ov=%b dz=%b",
                           e.re, e.im, e.known, e.ovf, e.dz, rsp_result_real, rsp_result_imag,
                           rsp_result_known, rsp_overflow, rsp_divide_by_zero);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_count <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count - 1;
      end else
         rsp_stall <= idle_on && ($urandom_range(99) < 30);
   end

   task automatic send_request(cmd_type c, logic [VALUE_WIDTH-1:0] opr,
                               logic [VALUE_WIDTH-1:0] opi, logic opk);
      if (idle_on && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_operand_real <= opr;
      req_operand_imag <= opi;
      req_operand_known <= opk;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return VALUE_WIDTH'($signed($urandom_range(8, 0)) - 4) <<< FRACTION_BITS;
         2: return {1'b0, {(VALUE_WIDTH-1){1'b1}}} - $urandom_range(2);
         3: return {1'b1, {(VALUE_WIDTH-1){1'b0}}} + $urandom_range(2);
         4: return VALUE_WIDTH'($signed($urandom_range(2000)) - 1000) <<< 8;
         default: return VALUE_WIDTH'($signed($urandom_range(64)) - 32);
      endcase
   endfunction

   task automatic test_directed();
      logic [VALUE_WIDTH-1:0] vmax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      logic [VALUE_WIDTH-1:0] vmin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      logic [VALUE_WIDTH-1:0] one = 1 << FRACTION_BITS;
      send_request(CMD_ADD, one, -one, 1'b1);
      send_request(CMD_LOAD, vmax, vmin, 1'b1);
      send_request(CMD_ADD, one, -one, 1'b1);
      send_request(CMD_SUB, -one, one, 1'b1);
      send_request(CMD_ABS, '0, '0, 1'b1);
      send_request(CMD_LOAD, vmin, 3 * one, 1'b1);
      send_request(CMD_ABS, '0, '0, 1'b0);
      send_request(CMD_SWAP, '1, '1, 1'b0);
      send_request(CMD_MUL, 2 * one, one, 1'b1);
      send_request(CMD_LOAD, 5 * one, -3 * one, 1'b1);
      send_request(CMD_DIV, '0, '0, 1'b1);
      send_request(CMD_LOAD, 0, -one, 1'b1);
      send_request(CMD_DIV, '0, '0, 1'b1);
      send_request(CMD_LOAD, 7 * one, 2 * one, 1'b1);
      send_request(CMD_DIV, 3 * one, -one, 1'b1);
      send_request(CMD_DIV, 1, 0, 1'b1);
      send_request(CMD_MUL, vmin, vmin, 1'b1);
      send_request(CMD_NOP, vmax, vmax, 1'b0);
      send_request(CMD_ADD, one, one, 1'b0);
      send_request(CMD_LOAD, 1, -1, 1'b0);
      send_request(CMD_MUL, 1, 1, 1'b1);
      send_request(CMD_LOAD, one, one, 1'b1);
   endtask

   task automatic test_random(int count);
      cmd_type c;
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) idle_on = 1'b0;
         if (i == count / 2) idle_on = 1'b1;
         c = ($urandom_range(9) == 0) ? CMD_LOAD : cmd_type'($urandom_range(7));
         send_request(c, pick_value(), pick_value(), $urandom_range(9) != 0);
      end
   endtask

   task automatic test_backpressure();
      @(negedge clock);
      hold_go = 1'b1;
      for (int i = 0; i < 20; i++)
         send_request(cmd_type'($urandom_range(7)), pick_value(), pick_value(), 1'b1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(810);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Ran %0d requests and checked %0d results: all commands, extremes,",
               request_count, result_count);
      $display("saturation, divide by zero, unknown operands and a long output stall.");
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("** complex_accumulator_alu: PASSED **");
      else
         $display("** complex_accumulator_alu: FAILED **");
      $finish;
   end

   initial begin
      #10ms;
      $display("Timeout with %0d results pending", pending_results.size());
      $display("** complex_accumulator_alu: FAILED **");
      $finish;
   end

endmodule
